// ----- src/smps_pkg.sv -----
// ----------------------------------------------------------------------------
// smps_pkg
// Shared types and constants of the score map peak suppression core.
// ----------------------------------------------------------------------------
package smps_pkg;

    localparam int FIELD_W = 12;
    localparam int POS_W   = 13;
    localparam int SCORE_W = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_DIST  = 2'd1;
    localparam logic [1:0] REG_OFFSET_X  = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y  = 2'd3;

    localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = 16'sd26214;
    localparam logic [FIELD_W-1:0]        MIN_DIST_RST  = 12'd8;

    typedef struct packed {
        logic [POS_W-1:0]          x;
        logic [POS_W-1:0]          y;
        logic signed [SCORE_W-1:0] score;
    } t_peak;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

endpackage

// ----- src/smps_in_if.sv -----
// ----------------------------------------------------------------------------
// smps_in_if
// Score input channel: valid/ready handshake with one score map sample.
// ----------------------------------------------------------------------------
interface smps_in_if;
    import smps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FIELD_W-1:0]        col;
    logic [FIELD_W-1:0]        row;
    logic signed [SCORE_W-1:0] score;
    logic                      first_item;
    logic                      last_item;

    modport source (output valid, col, row, score, first_item, last_item, input ready);
    modport sink   (input valid, col, row, score, first_item, last_item, output ready);
endinterface

// ----- src/smps_out_if.sv -----
// ----------------------------------------------------------------------------
// smps_out_if
// Peak output channel: valid/ready handshake with one stored peak.
// ----------------------------------------------------------------------------
interface smps_out_if;
    import smps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          peak_x;
    logic [POS_W-1:0]          peak_y;
    logic signed [SCORE_W-1:0] peak_score;
    logic                      last_peak;
    logic                      list_empty;
    logic                      overflowed;

    modport source (output valid, peak_x, peak_y, peak_score, last_peak, list_empty,
                    overflowed, input ready);
    modport sink   (input valid, peak_x, peak_y, peak_score, last_peak, list_empty,
                    overflowed, output ready);
endinterface

// ----- src/score_map_peak_suppression_core.sv -----
// ----------------------------------------------------------------------------
// score_map_peak_suppression_core
// Greedy non-maximum suppression of template match scores with a peak table.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | transaction
//  i_in     | in  | valid / ready        | col, row, score, first_item, last_item
//  o_out    | out | valid / ready        | peak_x, peak_y, peak_score, flags
//  apb      | in  | psel/penable/pwrite  | threshold, min distance, offsets
//
//  A below-threshold score is not stored. A match searches the table, which has
//  one read port; one stored peak is compared per cycle, newest first, stopping
//  at the first near peak.
//  A last_item then emits every stored peak (or one empty-list marker) and can stall on the output.
//  Reset clears control state and the APB registers; data registers and table contents stay undefined.
//  The output register lets the final peak wait while the next score is accepted.
// ----------------------------------------------------------------------------
module score_map_peak_suppression_core #(
    parameter int MAX_PEAKS  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    smps_in_if.sink                           i_in,
    smps_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smps_pkg::APB_AW-1:0]       paddr,
    input  logic [smps_pkg::APB_DW-1:0]       pwdata,
    output logic [smps_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import smps_pkg::*;

    localparam int CW = $clog2(MAX_PEAKS + 1);
    localparam int AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CB = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((1 << CB) - 1);
    localparam logic [CW-1:0]      CNT_MAX = CW'(MAX_PEAKS);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic [CW-1:0]             r_idx, n_idx;
    logic [AW-1:0]             r_cmp_idx, n_cmp_idx;
    logic                      r_pend, n_pend;
    logic [POS_W-1:0]          r_px, n_px;
    logic [POS_W-1:0]          r_py, n_py;
    logic signed [SCORE_W-1:0] r_score, n_score;
    logic                      r_last, n_last;

    logic signed [SCORE_W-1:0] r_thresh;
    logic [FIELD_W-1:0]        r_min_dist;
    logic [FIELD_W-1:0]        r_off_x;
    logic [FIELD_W-1:0]        r_off_y;

    t_peak                     r_mem [MAX_PEAKS];
    t_peak                     r_mem_q;

    logic                      r_ovalid, n_ovalid;
    t_peak                     r_opeak, n_opeak;
    logic                      r_olast, n_olast;
    logic                      r_oempty, n_oempty;
    logic                      r_oovf, n_oovf;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    t_peak                     wr_data;

    logic                      in_acc;
    logic                      cfg_wr;
    logic                      out_free;
    logic                      near;
    logic [POS_W-1:0]          dx;
    logic [POS_W-1:0]          dy;
    logic [CW-1:0]             base_cnt;
    logic [CW-1:0]             idx_dec;
    logic [CW-1:0]             cnt_dec;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign out_free   = !r_ovalid || o_out.ready;

    assign o_out.valid      = r_ovalid;
    assign o_out.peak_x     = r_opeak.x;
    assign o_out.peak_y     = r_opeak.y;
    assign o_out.peak_score = r_opeak.score;
    assign o_out.last_peak  = r_olast;
    assign o_out.list_empty = r_oempty;
    assign o_out.overflowed = r_oovf;

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = APB_DW'(signed'(r_thresh));
            REG_MIN_DIST:  prdata = APB_DW'(r_min_dist);
            REG_OFFSET_X:  prdata = APB_DW'(r_off_x);
            REG_OFFSET_Y:  prdata = APB_DW'(r_off_y);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= THRESHOLD_RST;
            r_min_dist <= MIN_DIST_RST;
            r_off_x    <= '0;
            r_off_y    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_THRESHOLD: r_thresh   <= pwdata[SCORE_W-1:0];
                REG_MIN_DIST:  r_min_dist <= pwdata[FIELD_W-1:0];
                REG_OFFSET_X:  r_off_x    <= pwdata[FIELD_W-1:0];
                REG_OFFSET_Y:  r_off_y    <= pwdata[FIELD_W-1:0];
                default:       r_off_y    <= r_off_y;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    assign dx      = (r_px > r_mem_q.x) ? r_px - r_mem_q.x : r_mem_q.x - r_px;
    assign dy      = (r_py > r_mem_q.y) ? r_py - r_mem_q.y : r_mem_q.y - r_py;
    assign near    = (dx < {1'b0, r_min_dist}) && (dy < {1'b0, r_min_dist});
    assign base_cnt = i_in.first_item ? '0 : r_count;
    assign idx_dec = r_idx - CW'(1);
    assign cnt_dec = r_count - CW'(1);
    assign wr_data = '{x: r_px, y: r_py, score: r_score};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = r_pend;
        n_px      = r_px;
        n_py      = r_py;
        n_score   = r_score;
        n_last    = r_last;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_opeak   = r_opeak;
        n_olast   = r_olast;
        n_oempty  = r_oempty;
        n_oovf    = r_oovf;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_count = base_cnt;
                    n_ovf   = i_in.first_item ? 1'b0 : r_ovf;
                    n_px    = POS_W'(i_in.col & CMASK) + POS_W'(r_off_x & CMASK);
                    n_py    = POS_W'(i_in.row & CMASK) + POS_W'(r_off_y & CMASK);
                    n_score = i_in.score;
                    n_last  = i_in.last_item;
                    n_pend  = 1'b0;
                    if (i_in.score >= r_thresh) begin
                        n_idx   = base_cnt;
                        n_state = S_SEARCH;
                    end else if (i_in.last_item) begin
                        n_idx   = '0;
                        n_state = S_EMIT;
                    end
                end
            end

            S_SEARCH: begin
                if (r_pend && near) begin
                    if (r_mem_q.score < r_score) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cmp_idx;
                    end
                    n_pend  = 1'b0;
                    n_idx   = '0;
                    n_state = r_last ? S_EMIT : S_IDLE;
                end else if (r_idx != '0) begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_dec[AW-1:0];
                    n_cmp_idx = idx_dec[AW-1:0];
                    n_idx     = idx_dec;
                    n_pend    = 1'b1;
                end else begin
                    if (r_count < CNT_MAX) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_pend  = 1'b0;
                    n_idx   = '0;
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end

            S_EMIT: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_opeak  = '0;
                        n_olast  = 1'b1;
                        n_oempty = 1'b1;
                        n_oovf   = r_ovf;
                        n_state  = S_IDLE;
                    end
                end else begin
                    if (r_pend && out_free) begin
                        n_ovalid = 1'b1;
                        n_opeak  = r_mem_q;
                        n_olast  = (r_cmp_idx == cnt_dec[AW-1:0]);
                        n_oempty = 1'b0;
                        n_oovf   = r_ovf;
                        n_pend   = 1'b0;
                        if (r_cmp_idx == cnt_dec[AW-1:0]) begin
                            n_state = S_IDLE;
                        end
                    end
                    if ((!r_pend || out_free) && (r_idx < r_count)) begin
                        rd_en     = 1'b1;
                        rd_addr   = r_idx[AW-1:0];
                        n_cmp_idx = r_idx[AW-1:0];
                        n_idx     = r_idx + CW'(1);
                        n_pend    = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_px      <= n_px;
        r_py      <= n_py;
        r_score   <= n_score;
        r_last    <= n_last;
        r_opeak   <= n_opeak;
        r_olast   <= n_olast;
        r_oempty  <= n_oempty;
        r_oovf    <= n_oovf;
    end

endmodule

// ----- test/tb_score_map_peak_suppression_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_score_map_peak_suppression_core
// Self-checking bench for the peak suppression core. Scores are sent with or
// without random gaps on the input channel. A built-in peak table predicts each emitted
// peak list, and the results are compared field by field in arrival order.
// Covers reset defaults, merge rules, threshold and offset extremes, table
// overflow, long output back-pressure and random phases of register settings.
// ----------------------------------------------------------------------------
module tb_score_map_peak_suppression_core;
    import smps_pkg::*;

    typedef struct packed {
        t_peak peak;
        logic  last_peak;
        logic  list_empty;
        logic  overflowed;
    } t_peak_result;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 100;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    smps_in_if  in_if ();
    smps_out_if out_if ();

    score_map_peak_suppression_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [SCORE_W-1:0] cfg_threshold;
    logic [FIELD_W-1:0]        cfg_min_dist;
    logic [FIELD_W-1:0]        cfg_offset_x;
    logic [FIELD_W-1:0]        cfg_offset_y;
    t_peak                     peak_table [TABLE_DEPTH];
    int                        peak_count;
    logic                      table_overflow;
    t_peak_result              expected_peaks [$];

    int   mismatch_count = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    logic rx_hold = 1'b0;

    always #4 i_clk = ~i_clk;

    task automatic predict_peak_list(input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row,
                                     input logic signed [SCORE_W-1:0] score,
                                     input logic first_item, input logic last_item);
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        int               dx;
        int               dy;
        int               idx;
        bit               near_found;
        t_peak_result     res;
        if (first_item) begin
            peak_count     = 0;
            table_overflow = 1'b0;
        end
        if (score >= cfg_threshold) begin
            px         = {1'b0, col} + {1'b0, cfg_offset_x};
            py         = {1'b0, row} + {1'b0, cfg_offset_y};
            near_found = 1'b0;
            idx        = peak_count - 1;
            while (idx >= 0 && !near_found) begin
                dx = int'(px) - int'(peak_table[idx].x);
                dy = int'(py) - int'(peak_table[idx].y);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx < int'(cfg_min_dist) && dy < int'(cfg_min_dist)) begin
                    near_found = 1'b1;
                    if ($signed(peak_table[idx].score) < score) begin
                        peak_table[idx].x     = px;
                        peak_table[idx].y     = py;
                        peak_table[idx].score = score;
                    end
                end
                idx--;
            end
            if (!near_found) begin
                if (peak_count < TABLE_DEPTH) begin
                    peak_table[peak_count].x     = px;
                    peak_table[peak_count].y     = py;
                    peak_table[peak_count].score = score;
                    peak_count++;
                end else begin
                    table_overflow = 1'b1;
                end
            end
        end
        if (last_item) begin
            if (peak_count == 0) begin
                res            = '0;
                res.last_peak  = 1'b1;
                res.list_empty = 1'b1;
                res.overflowed = table_overflow;
                expected_peaks.push_back(res);
            end else begin
                for (int k = 0; k < peak_count; k++) begin
                    res.peak       = peak_table[k];
                    res.last_peak  = (k == peak_count - 1);
                    res.list_empty = 1'b0;
                    res.overflowed = table_overflow;
                    expected_peaks.push_back(res);
                end
            end
        end
    endtask

    task automatic send_score(input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row,
                              input logic signed [SCORE_W-1:0] score,
                              input logic first_item, input logic last_item);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.col        <= col;
        in_if.row        <= row;
        in_if.score      <= score;
        in_if.first_item <= first_item;
        in_if.last_item  <= last_item;
        do @(posedge i_clk); while (!in_if.ready);
        predict_peak_list(col, row, score, first_item, last_item);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD: cfg_threshold = value[SCORE_W-1:0];
            REG_MIN_DIST:  cfg_min_dist  = value[FIELD_W-1:0];
            REG_OFFSET_X:  cfg_offset_x  = value[FIELD_W-1:0];
            REG_OFFSET_Y:  cfg_offset_y  = value[FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic signed [SCORE_W-1:0] threshold,
                              input logic [FIELD_W-1:0] min_dist,
                              input logic [FIELD_W-1:0] offset_x,
                              input logic [FIELD_W-1:0] offset_y);
        write_reg(REG_THRESHOLD, {{(APB_DW-SCORE_W){threshold[SCORE_W-1]}}, threshold});
        write_reg(REG_MIN_DIST, APB_DW'(min_dist));
        write_reg(REG_OFFSET_X, APB_DW'(offset_x));
        write_reg(REG_OFFSET_Y, APB_DW'(offset_y));
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frame(input int len);
        logic [FIELD_W-1:0]        base_x;
        logic [FIELD_W-1:0]        base_y;
        logic [FIELD_W-1:0]        col;
        logic [FIELD_W-1:0]        row;
        logic signed [SCORE_W-1:0] score;
        int                        win;
        int                        lo;
        int                        s;
        win    = 4 * int'(cfg_min_dist) + 8;
        if (win > 4095) win = 4095;
        lo     = int'(cfg_threshold);
        base_x = FIELD_W'($urandom);
        base_y = FIELD_W'($urandom);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                s     = lo + int'($urandom_range(0, 32767 - lo));
                score = s[SCORE_W-1:0];
            end else begin
                score = SCORE_W'($urandom);
            end
            col = base_x + FIELD_W'($urandom_range(0, win));
            row = base_y + FIELD_W'($urandom_range(0, win));
            send_score(col, row, score,
                       (n == 0) || ($urandom_range(0, 19) == 0),
                       (n == len - 1) || ($urandom_range(0, 19) == 0));
        end
    endtask

    task automatic test_empty_list();
        send_score(12'd0, 12'd0, -16'sd32768, 1'b1, 1'b1);
        send_score(12'hFFF, 12'hFFF, 16'sd26213, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_threshold_at_reset();
        send_score(12'd0, 12'd0, 16'sd26214, 1'b1, 1'b0);
        send_score(12'hFFF, 12'hFFF, 16'sd32767, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_merge_rules();
        send_score(12'd100, 12'd100, 16'sd27000, 1'b1, 1'b0);
        send_score(12'd105, 12'd103, 16'sd27000, 1'b0, 1'b0);
        send_score(12'd107, 12'd96, 16'sd28000, 1'b0, 1'b0);
        send_score(12'd200, 12'd100, 16'sd30000, 1'b0, 1'b0);
        send_score(12'd203, 12'd101, 16'sd29000, 1'b0, 1'b0);
        send_score(12'd104, 12'd99, 16'sd31000, 1'b0, 1'b0);
        send_score(12'd112, 12'd99, 16'sd27000, 1'b0, 1'b0);
        send_score(12'd108, 12'd99, 16'sd32000, 1'b0, 1'b0);
        send_score(12'd0, 12'd0, -16'sd1, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_table_after_emit();
        send_score(12'd0, 12'd0, -16'sd1, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_THRESHOLD, 32'h0000_7FFF);
        send_score(12'd10, 12'd20, 16'sd32766, 1'b1, 1'b0);
        send_score(12'd10, 12'd20, 16'sd32767, 1'b0, 1'b1);
        wait_idle();
        write_reg(REG_THRESHOLD, 32'hFFFF_8000);
        send_score(12'd5, 12'd5, -16'sd32768, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_distance_offsets();
        set_config(-16'sd32768, 12'd0, 12'hFFF, 12'hFFF);
        send_score(12'hFFF, 12'hFFF, 16'sd1, 1'b1, 1'b0);
        send_score(12'hFFF, 12'hFFF, 16'sd2, 1'b0, 1'b0);
        send_score(12'd0, 12'd0, -16'sd32768, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_table_overflow();
        set_config(-16'sd32768, 12'd0, FIELD_W'($urandom), FIELD_W'($urandom));
        for (int n = 0; n < 70; n++)
            send_score(FIELD_W'($urandom), FIELD_W'($urandom), SCORE_W'($urandom),
                       n == 0, n == 69);
        send_score(FIELD_W'($urandom), FIELD_W'($urandom), SCORE_W'($urandom), 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        set_config(16'sd0, 12'd4, 12'd0, 12'd0);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (600) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                for (int f = 0; f < 5; f++) send_frame(8);
            end
        join
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic signed [SCORE_W-1:0] threshold;
        logic [FIELD_W-1:0]        min_dist;
        logic [FIELD_W-1:0]        offset_x;
        logic [FIELD_W-1:0]        offset_y;
        int                        sent;
        int                        len;
        int                        s;
        for (int phase = 0; phase < 8; phase++) begin
            tx_idle = (phase % 4 == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_idle = (phase % 4 == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: threshold = -16'sd32768;
                1: threshold = 16'sd32767;
                default: begin
                    s         = int'($urandom_range(0, 40000)) - 8000;
                    threshold = s[SCORE_W-1:0];
                end
            endcase
            case ($urandom_range(0, 3))
                0: min_dist = 12'd0;
                1: min_dist = 12'd2048;
                2: min_dist = FIELD_W'($urandom_range(1, 16));
                default: min_dist = FIELD_W'($urandom_range(1, 2048));
            endcase
            case ($urandom_range(0, 2))
                0: offset_x = 12'd0;
                1: offset_x = 12'hFFF;
                default: offset_x = FIELD_W'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0: offset_y = 12'd0;
                1: offset_y = 12'hFFF;
                default: offset_y = FIELD_W'($urandom);
            endcase
            set_config(threshold, min_dist, offset_x, offset_y);
            sent = 0;
            while (sent < 35) begin
                len = $urandom_range(1, 12);
                send_frame(len);
                sent += len;
            end
            wait_idle();
        end
    endtask

    initial begin
        int rx_gap;
        rx_gap = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
            if (rx_hold) begin
                out_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                out_if.ready <= 1'b0;
                rx_gap--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_peak_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_peaks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected peak: x=%0d y=%0d score=%0d last=%0b empty=%0b ovf=%0b",
                             out_if.peak_x, out_if.peak_y, out_if.peak_score,
                             out_if.last_peak, out_if.list_empty, out_if.overflowed);
            end else begin
                want = expected_peaks.pop_front();
                if (out_if.peak_x !== want.peak.x || out_if.peak_y !== want.peak.y ||
                    out_if.peak_score !== want.peak.score ||
                    out_if.last_peak !== want.last_peak ||
                    out_if.list_empty !== want.list_empty ||
                    out_if.overflowed !== want.overflowed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp x=%0d y=%0d score=%0d last=%0b empty=%0b ovf=%0b",
                                 want.peak.x, want.peak.y, $signed(want.peak.score),
                                 want.last_peak, want.list_empty, want.overflowed);
                        $display("mismatch got x=%0d y=%0d score=%0d last=%0b empty=%0b ovf=%0b",
                                 out_if.peak_x, out_if.peak_y, out_if.peak_score,
                                 out_if.last_peak, out_if.list_empty, out_if.overflowed);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.col        <= '0;
        in_if.row        <= '0;
        in_if.score      <= '0;
        in_if.first_item <= 1'b0;
        in_if.last_item  <= 1'b0;
        cfg_threshold    = THRESHOLD_RST;
        cfg_min_dist     = MIN_DIST_RST;
        cfg_offset_x     = '0;
        cfg_offset_y     = '0;
        peak_count       = 0;
        table_overflow   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_threshold_at_reset();
        test_merge_rules();
        test_table_after_emit();
        test_threshold_extremes();
        test_zero_distance_offsets();
        test_table_overflow();
        test_output_backpressure();
        test_random_phases();

        if (mismatch_count == 0) begin
            $display("tb_score_map_peak_suppression_core: PASS");
        end else begin
            $display("tb_score_map_peak_suppression_core: FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_score_map_peak_suppression_core: FAIL");
        $finish;
    end

endmodule
